// ----- rtl/qa_pkg.sv -----
// quaternion alu package: formats, command codes, item types and helpers
`default_nettype none
package qa_pkg;

  // component format, Q2.13 by default
  localparam int unsigned W  = 16;
  localparam int unsigned F  = 13;
  // width of a sum of four full products
  localparam int unsigned SW = 2 * W + 2;
  // square root: one result bit per step
  localparam int unsigned NS  = W + 1;
  localparam int unsigned RTW = W + 1;
  localparam int unsigned RMW = W + 3;

  typedef enum logic [2:0] {
    CmdAdd   = 3'd0,
    CmdSub   = 3'd1,
    CmdScale = 3'd2,
    CmdMul   = 3'd3,
    CmdMag   = 3'd4,
    CmdIdent = 3'd5
  } qa_cmd_e;

  typedef struct packed {
    logic [2:0]          cmd;
    logic signed [W-1:0] a_x;
    logic signed [W-1:0] a_y;
    logic signed [W-1:0] a_z;
    logic signed [W-1:0] a_w;
    logic signed [W-1:0] b_x;
    logic signed [W-1:0] b_y;
    logic signed [W-1:0] b_z;
    logic signed [W-1:0] b_w;
    logic signed [W-1:0] scale_factor;
  } qa_in_t;

  typedef struct packed {
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [W-1:0] r_z;
    logic signed [W-1:0] r_w;
    logic [W-1:0]        norm;
    logic                is_identity;
    logic                overflow;
  } qa_out_t;

  // item travelling beside the square root steps
  typedef struct packed {
    logic [2:0]          cmd;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [W-1:0] r_z;
    logic signed [W-1:0] r_w;
    logic                ident;
    logic                ovf;
  } qa_pipe_t;

  typedef struct packed {
    logic [SW-1:0]  rad;
    logic [RTW-1:0] root;
    logic [RMW-1:0] rem;
  } qa_sqrt_t;

  // clip a wide signed value to the component range
  function automatic logic [W:0] sat_w(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    lo = -SW'(64'sd1 <<< (W - 1));
    if (v > hi) begin
      sat_w = {1'b1, hi[W-1:0]};
    end else if (v < lo) begin
      sat_w = {1'b1, lo[W-1:0]};
    end else begin
      sat_w = {1'b0, v[W-1:0]};
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/quaternion_alu_top.sv -----
// quaternion alu top level: products, sums, rounding, pipelined square root
// each item passes the stage 1, stage 2 and stage 3 registers, the square root steps and the output register
// throughput: one item per cycle, every command; busy stays low
// the square root of the magnitude takes one stage per result bit (17 stages)
// reset clears all valid bits and sets the tolerance register to 8
// results cannot be held off; done_o marks each for one cycle
`default_nettype none
module quaternion_alu_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire qa_pkg::qa_in_t in_i,
  output logic                done_o,
  output qa_pkg::qa_out_t     res_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [qa_pkg::W-2:0] cfg_data_i
);

  localparam int unsigned W   = qa_pkg::W;
  localparam int unsigned F   = qa_pkg::F;
  localparam int unsigned SW  = qa_pkg::SW;
  localparam int unsigned NS  = qa_pkg::NS;
  localparam int unsigned RTW = qa_pkg::RTW;
  localparam int unsigned RMW = qa_pkg::RMW;
  localparam int unsigned PW  = 2 * W;

  // always ready
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // tolerance register
  logic [W-2:0] tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= (W-1)'(8);
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  // stage 1: sixteen products, add/sub, identity compare
  logic signed [W-1:0] a_c [4];
  logic signed [W-1:0] b_c [4];
  logic signed [W-1:0] op_c [4];
  logic signed [PW-1:0] p1_d [4][4];
  logic signed [PW-1:0] p1_q [4][4];
  logic signed [W:0]   as1_d [4];
  logic signed [W:0]   as1_q [4];
  logic                id1_d, id1_q;
  logic [2:0]          cmd1_q;
  logic                v1_q;
  logic [W:0]          abs_c [3];
  logic signed [W+1:0] wd_c;
  logic [W+1:0]        wabs_c;

  always_comb begin
    a_c[0] = in_i.a_x; a_c[1] = in_i.a_y; a_c[2] = in_i.a_z; a_c[3] = in_i.a_w;
    b_c[0] = in_i.b_x; b_c[1] = in_i.b_y; b_c[2] = in_i.b_z; b_c[3] = in_i.b_w;
    for (int j = 0; j < 4; j++) begin
      if (in_i.cmd == qa_pkg::CmdMul) begin
        op_c[j] = b_c[j];
      end else if (in_i.cmd == qa_pkg::CmdScale) begin
        op_c[j] = in_i.scale_factor;
      end else begin
        op_c[j] = a_c[j];
      end
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p1_d[i][j] = PW'(a_c[i]) * PW'(op_c[j]);
      end
      if (in_i.cmd == qa_pkg::CmdSub) begin
        as1_d[i] = (W+1)'(a_c[i]) - (W+1)'(b_c[i]);
      end else begin
        as1_d[i] = (W+1)'(a_c[i]) + (W+1)'(b_c[i]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      abs_c[i] = a_c[i][W-1] ? (W+1)'(-(W+1)'(a_c[i])) : (W+1)'(a_c[i]);
    end
    wd_c   = (W+2)'(a_c[3]) - (W+2)'(64'sd1 <<< F);
    wabs_c = wd_c[W+1] ? (W+2)'(-wd_c) : (W+2)'(wd_c);
    id1_d  = (abs_c[0] <= (W+1)'(tol_q)) && (abs_c[1] <= (W+1)'(tol_q))
          && (abs_c[2] <= (W+1)'(tol_q)) && (wabs_c <= (W+2)'(tol_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q   <= p1_d;
    as1_q  <= as1_d;
    id1_q  <= id1_d;
    cmd1_q <= in_i.cmd;
  end

  // stage 2: sums of products
  logic signed [SW-1:0] e_c [4][4];
  logic signed [SW-1:0] vs2_d [4];
  logic signed [SW-1:0] vs2_q [4];
  logic signed [SW-1:0] ms2_d, ms2_q;
  logic signed [W:0]    as2_q [4];
  logic                 id2_q;
  logic [2:0]           cmd2_q;
  logic                 v2_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        e_c[i][j] = SW'(p1_q[i][j]);
      end
    end
    if (cmd1_q == qa_pkg::CmdMul) begin
      vs2_d[0] = e_c[3][0] + e_c[0][3] + e_c[1][2] - e_c[2][1];
      vs2_d[1] = e_c[3][1] - e_c[0][2] + e_c[1][3] + e_c[2][0];
      vs2_d[2] = e_c[3][2] + e_c[0][1] - e_c[1][0] + e_c[2][3];
      vs2_d[3] = e_c[3][3] - e_c[0][0] - e_c[1][1] - e_c[2][2];
    end else begin
      for (int i = 0; i < 4; i++) begin
        vs2_d[i] = e_c[i][0];
      end
    end
    ms2_d = e_c[0][0] + e_c[1][1] + e_c[2][2] + e_c[3][3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vs2_q  <= vs2_d;
    ms2_q  <= ms2_d;
    as2_q  <= as1_q;
    id2_q  <= id1_q;
    cmd2_q <= cmd1_q;
  end

  // stage 3: round, saturate and pick fields by command
  qa_pkg::qa_pipe_t     pp3_d;
  logic signed [SW-1:0] rnd_c [4];
  logic [W:0]           sv_c [4];
  logic [W:0]           sa_c [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rnd_c[i] = (vs2_q[i] + SW'(64'sd1 <<< (F - 1))) >>> F;
      sv_c[i]  = qa_pkg::sat_w(rnd_c[i]);
      sa_c[i]  = qa_pkg::sat_w(SW'(as2_q[i]));
    end
    pp3_d       = '0;
    pp3_d.cmd   = cmd2_q;
    case (cmd2_q) inside
      qa_pkg::CmdAdd, qa_pkg::CmdSub: begin
        pp3_d.r_x = sa_c[0][W-1:0];
        pp3_d.r_y = sa_c[1][W-1:0];
        pp3_d.r_z = sa_c[2][W-1:0];
        pp3_d.r_w = sa_c[3][W-1:0];
        pp3_d.ovf = sa_c[0][W] | sa_c[1][W] | sa_c[2][W] | sa_c[3][W];
      end
      qa_pkg::CmdScale, qa_pkg::CmdMul: begin
        pp3_d.r_x = sv_c[0][W-1:0];
        pp3_d.r_y = sv_c[1][W-1:0];
        pp3_d.r_z = sv_c[2][W-1:0];
        pp3_d.r_w = sv_c[3][W-1:0];
        pp3_d.ovf = sv_c[0][W] | sv_c[1][W] | sv_c[2][W] | sv_c[3][W];
      end
      qa_pkg::CmdIdent: begin
        pp3_d.ident = id2_q;
      end
      default: begin
        pp3_d.ovf = 1'b0;
      end
    endcase
  end

  // square root steps, index 0 is the stage 3 register
  qa_pkg::qa_pipe_t pp_q [NS+1];
  qa_pkg::qa_sqrt_t sq_q [NS+1];
  logic             vp_q [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q[0] <= 1'b0;
    end else begin
      vp_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q[0]      <= pp3_d;
    sq_q[0].rad  <= {1'b0, ms2_q[SW-2:0]};
    sq_q[0].root <= '0;
    sq_q[0].rem  <= '0;
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [RMW+1:0]   cur_c;
    logic [RMW+1:0]   trial_c;
    qa_pkg::qa_sqrt_t nx_c;

    always_comb begin
      cur_c   = {sq_q[k].rem, sq_q[k].rad[SW-1:SW-2]};
      trial_c = (RMW+2)'({sq_q[k].root, 2'b01});
      nx_c.rad = {sq_q[k].rad[SW-3:0], 2'b00};
      if (cur_c >= trial_c) begin
        nx_c.rem  = RMW'(cur_c - trial_c);
        nx_c.root = {sq_q[k].root[RTW-2:0], 1'b1};
      end else begin
        nx_c.rem  = cur_c[RMW-1:0];
        nx_c.root = {sq_q[k].root[RTW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vp_q[k+1] <= 1'b0;
      end else begin
        vp_q[k+1] <= vp_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      pp_q[k+1] <= pp_q[k];
      sq_q[k+1] <= nx_c;
    end
  end

  // output stage: round the root to nearest and clip
  qa_pkg::qa_out_t res_d, res_q;
  logic            done_q;
  logic [RTW:0]    nr_c;
  qa_pkg::qa_pipe_t pl_c;

  always_comb begin
    pl_c = pp_q[NS];
    nr_c = (RTW+1)'(sq_q[NS].root)
         + (RTW+1)'((RMW+1)'(sq_q[NS].rem) > (RMW+1)'(sq_q[NS].root));
    res_d.r_x         = pl_c.r_x;
    res_d.r_y         = pl_c.r_y;
    res_d.r_z         = pl_c.r_z;
    res_d.r_w         = pl_c.r_w;
    res_d.is_identity = pl_c.ident;
    res_d.overflow    = pl_c.ovf;
    res_d.norm        = '0;
    if (pl_c.cmd == qa_pkg::CmdMag) begin
      if (nr_c[RTW:W] != '0) begin
        res_d.norm     = '1;
        res_d.overflow = 1'b1;
      end else begin
        res_d.norm = nr_c[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vp_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // checks on the delivered fields
  a_ident_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.is_identity |-> res_o.norm == '0 && !res_o.overflow
      && res_o.r_x == '0 && res_o.r_w == '0)
    else $error("identity result carries other fields");

  a_norm_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.norm != '0 |-> !res_o.is_identity && res_o.r_x == '0
      && res_o.r_y == '0 && res_o.r_z == '0 && res_o.r_w == '0)
    else $error("magnitude result carries vector fields");

  a_norm_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.overflow && res_o.norm != '0 |-> res_o.norm == '1)
    else $error("clipped magnitude not at full scale");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vp_q[NS]))
    else $error("result without an item in the last root stage");

endmodule
`default_nettype wire

// ----- sim/tb_quaternion_alu_top.sv -----
// testbench for the quaternion alu: random and directed items checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_quaternion_alu_top;
  import qa_pkg::*;

  // expected results in arrival order, compared field by field
  class qa_result_board;
    qa_out_t pending[$];
    int      errors;
    int      checked;

    function void note_item(qa_out_t exp_res);
      pending.push_back(exp_res);
    endfunction

    task automatic check_result(qa_out_t got);
      qa_out_t exp_res;
      if (pending.size() == 0) begin
        report_mismatch("result with none expected", 0, got);
      end else begin
        exp_res = pending.pop_front();
        checked++;
        if (got.r_x !== exp_res.r_x) report_mismatch("r_x", exp_res.r_x, got.r_x);
        if (got.r_y !== exp_res.r_y) report_mismatch("r_y", exp_res.r_y, got.r_y);
        if (got.r_z !== exp_res.r_z) report_mismatch("r_z", exp_res.r_z, got.r_z);
        if (got.r_w !== exp_res.r_w) report_mismatch("r_w", exp_res.r_w, got.r_w);
        if (got.norm !== exp_res.norm) report_mismatch("norm", exp_res.norm, got.norm);
        if (got.is_identity !== exp_res.is_identity)
          report_mismatch("is_identity", exp_res.is_identity, got.is_identity);
        if (got.overflow !== exp_res.overflow)
          report_mismatch("overflow", exp_res.overflow, got.overflow);
      end
    endtask

    task automatic report_mismatch(string what, logic [127:0] e, logic [127:0] g);
      errors++;
      if (errors <= 50) $display("mismatch %s: expected %0h got %0h", what, e, g);
    endtask
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  qa_in_t        in_i;
  logic          done_o;
  qa_out_t       res_o;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [W-2:0]  cfg_data_i;

  qa_result_board board;
  logic [W-2:0]   tol_q;
  bit             no_gaps;
  int             n_items;
  int             cmd_seen[8];

  quaternion_alu_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // clip to the component range
  function automatic logic signed [W-1:0] clip(longint v, inout bit ovf);
    if (v > 32767) begin
      ovf = 1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      ovf = 1;
      return 16'sh8000;
    end
    return v[W-1:0];
  endfunction

  // round half up of a product sum with F fraction bits
  function automatic longint round_q(longint v);
    return (v + (64'sd1 <<< (F - 1))) >>> F;
  endfunction

  // expected outcome of one quaternion operation
  function automatic qa_out_t quat_predict(qa_in_t it, logic [W-2:0] tol);
    qa_out_t r;
    bit      ovf;
    longint  ax, ay, az, aw, bx, by, bz, bw, s, one, tl;
    longint unsigned sum, root;
    r   = '0;
    ovf = 0;
    ax = it.a_x; ay = it.a_y; az = it.a_z; aw = it.a_w;
    bx = it.b_x; by = it.b_y; bz = it.b_z; bw = it.b_w;
    s  = it.scale_factor;
    case (it.cmd)
      CmdAdd, CmdSub: begin
        if (it.cmd == CmdSub) begin
          bx = -bx; by = -by; bz = -bz; bw = -bw;
        end
        r.r_x = clip(ax + bx, ovf);
        r.r_y = clip(ay + by, ovf);
        r.r_z = clip(az + bz, ovf);
        r.r_w = clip(aw + bw, ovf);
      end
      CmdScale: begin
        r.r_x = clip(round_q(ax * s), ovf);
        r.r_y = clip(round_q(ay * s), ovf);
        r.r_z = clip(round_q(az * s), ovf);
        r.r_w = clip(round_q(aw * s), ovf);
      end
      CmdMul: begin
        r.r_x = clip(round_q(aw * bx + ax * bw + ay * bz - az * by), ovf);
        r.r_y = clip(round_q(aw * by - ax * bz + ay * bw + az * bx), ovf);
        r.r_z = clip(round_q(aw * bz + ax * by - ay * bx + az * bw), ovf);
        r.r_w = clip(round_q(aw * bw - ax * bx - ay * by - az * bz), ovf);
      end
      CmdMag: begin
        sum  = ax * ax + ay * ay + az * az + aw * aw;
        root = 0;
        for (int b = 20; b >= 0; b--) begin
          if ((root + (64'd1 << b)) * (root + (64'd1 << b)) <= sum) root += 64'd1 << b;
        end
        if (sum - root * root > root) root++;
        if (root > 65535) begin
          root = 65535;
          ovf  = 1;
        end
        r.norm = root[W-1:0];
      end
      CmdIdent: begin
        // signed compare against the tolerance
        one = 64'sd1 <<< F;
        tl  = tol;
        r.is_identity = (ax <= tl && -ax <= tl && ay <= tl && -ay <= tl &&
                         az <= tl && -az <= tl &&
                         aw - one <= tl && one - aw <= tl);
      end
      default: ;
    endcase
    if (it.cmd <= CmdMag) r.overflow = ovf;
    return r;
  endfunction

  // one random component: extremes, near identity, small or full range
  function automatic logic signed [W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return 16'sh2000 + $signed(16'($urandom_range(0, 40))) - 16'sd20;
      2: return $signed(16'($urandom_range(0, 40))) - 16'sd20;
      default: return 16'($urandom());
    endcase
  endfunction

  // start stays high between back to back items, drops during random gaps and is dropped by the caller
  task automatic send_item(qa_in_t it);
    int gap;
    if (!no_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_item(quat_predict(it, tol_q));
    cmd_seen[it.cmd]++;
    n_items++;
  endtask

  // random item, mostly legal commands with occasional undefined codes
  task automatic send_random();
    qa_in_t it;
    it = '0;
    it.cmd = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    it.a_x = rand_comp(); it.a_y = rand_comp(); it.a_z = rand_comp(); it.a_w = rand_comp();
    it.b_x = rand_comp(); it.b_y = rand_comp(); it.b_z = rand_comp(); it.b_w = rand_comp();
    it.scale_factor = rand_comp();
    if (it.cmd == CmdIdent && $urandom_range(0, 1)) begin
      it.a_w = 16'sh2000 + $signed(16'($urandom_range(0, 2 * tol_q + 2))) - $signed({1'b0, tol_q}) - 16'sd1;
      it.a_x = $signed(16'($urandom_range(0, 2 * tol_q))) - $signed({1'b0, tol_q});
      it.a_y = $signed(16'($urandom_range(0, 2 * tol_q))) - $signed({1'b0, tol_q});
      it.a_z = $signed(16'($urandom_range(0, 2 * tol_q + 1))) - $signed({1'b0, tol_q});
    end
    send_item(it);
  endtask

  // drain outstanding results, then write the tolerance
  task automatic write_tol(logic [W-2:0] v);
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    tol_q = v;
  endtask

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_result(res_o);
  end

  initial begin
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    qa_in_t it;
    logic [W-2:0] tols[5];
    board       = new();
    tol_q       = 15'd8;
    no_gaps     = 0;
    n_items     = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes on every command, identity at the edge of tolerance
    for (int c = 0; c < 8; c++) begin
      it = '0;
      it.cmd = 3'(c);
      it.a_x = 16'sh7fff; it.a_y = 16'sh8000; it.a_z = 16'sh7fff; it.a_w = 16'sh8000;
      it.b_x = 16'sh8000; it.b_y = 16'sh7fff; it.b_z = 16'sh8000; it.b_w = 16'sh7fff;
      it.scale_factor = 16'sh8000;
      send_item(it);
      it = '0;
      it.cmd = 3'(c);
      it.a_w = 16'sh2008; it.a_x = -16'sd8; it.b_w = 16'sh2000; it.scale_factor = 16'sh2000;
      send_item(it);
    end
    it = '0;
    it.cmd = CmdIdent; it.a_w = 16'sh2009;
    send_item(it);
    it.a_w = 16'sh1ff8; it.a_z = 16'sd8;
    send_item(it);
    it = '0;
    it.cmd = CmdMul; it.a_x = 16'sd1; it.b_x = 16'sd4096;
    send_item(it);
    it.b_x = -16'sd4096;
    send_item(it);

    // random phases across several tolerance settings
    tols = '{15'd0, 15'h7fff, 15'd8, 15'd100, 15'($urandom())};
    for (int p = 0; p < 5; p++) begin
      write_tol(tols[p]);
      for (int i = 0; i < 400; i++) begin
        if (p == 4 && i == 200) no_gaps = 1;
        send_random();
      end
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("covered %0d items: add %0d sub %0d scale %0d mul %0d mag %0d ident %0d",
             n_items, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4],
             cmd_seen[5]);
    $display("%0d results checked over five tolerance settings", board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
